/* rtl/sfd_pkg.sv */
// Shared types and constants for the serial frame deframer.
`default_nettype none
package sfd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 7;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned OutDataW  = 24;

  localparam logic [ByteW-1:0] SyncReset   = 8'h2A;
  localparam logic [LenW-1:0]  MaxPayReset = 7'd79;

  localparam logic [ByteW-1:0] CmdA = 8'h20;
  localparam logic [ByteW-1:0] CmdB = 8'h21;
  localparam logic [ByteW-1:0] CmdC = 8'h25;
  localparam logic [ByteW-1:0] CmdD = 8'h26;

  localparam logic [CfgIdxW-1:0] RegSyncByte   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMaxPayload = 1'd1;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_CMD   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] command_code;
    logic [LenW-1:0]  byte_index;
  } result_t;

  function automatic logic cmd_ok(input logic [ByteW-1:0] b);
    cmd_ok = (b == CmdA) || (b == CmdB) || (b == CmdC) || (b == CmdD);
  endfunction

endpackage
`default_nettype wire

/* rtl/sfd_parser.sv */
// Frame parse state machine with length, command and checksum logic.
`default_nettype none
module sfd_parser
  import sfd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [ByteW-1:0] rx_byte_i,
  input  wire logic             last_i,
  input  wire logic [ByteW-1:0] sync_byte_i,
  input  wire logic [LenW-1:0]  max_payload_i,
  output logic                  res_valid_o,
  output result_t               res_o
);

  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [ByteW-1:0] len_m1;
  logic [LenW-1:0]  cnt_inc;

  assign len_m1  = rx_byte_i - 8'd1;
  assign cnt_inc = cnt_q + 7'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      cmd_q   <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      cmd_q   <= cmd_d;
    end
  end

  always_comb begin
    phase_d            = PH_HUNT;
    len_d              = len_q;
    cnt_d              = cnt_q;
    sum_d              = sum_q;
    cmd_d              = cmd_q;
    res_valid_o        = 1'b0;
    res_o.kind         = KIND_DATA;
    res_o.data_byte    = rx_byte_i;
    res_o.command_code = cmd_q;
    res_o.byte_index   = cnt_q;
    unique case (phase_q)
      PH_LEN: begin
        if (rx_byte_i != 8'd0 && len_m1 <= {1'b0, max_payload_i}) begin
          len_d   = len_m1[LenW-1:0];
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        if (cmd_ok(rx_byte_i)) begin
          cmd_d   = rx_byte_i;
          sum_d   = rx_byte_i;
          cnt_d   = '0;
          phase_d = (len_q == '0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        res_valid_o = 1'b1;
        sum_d       = sum_q + rx_byte_i;
        cnt_d       = cnt_inc;
        phase_d     = (cnt_inc >= len_q) ? PH_CHECK : PH_DATA;
      end
      PH_CHECK: begin
        res_valid_o      = 1'b1;
        res_o.kind       = (sum_q == rx_byte_i) ? KIND_GOOD : KIND_BAD;
        res_o.byte_index = len_q;
      end
      default: begin
        phase_d = (rx_byte_i == sync_byte_i) ? PH_LEN : PH_HUNT;
      end
    endcase
    if (last_i) begin
      phase_d = PH_HUNT;
    end
  end

  a_data_cnt_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> cnt_q < len_q)
    else $error("payload count reached length while still in data phase");

  a_check_cnt_eq_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CHECK |-> cnt_q == len_q)
    else $error("checksum phase entered before all payload bytes");

  a_last_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && last_i |=> phase_q == PH_HUNT)
    else $error("parser not hunting after end of chunk");

endmodule
`default_nettype wire

/* rtl/sfd_out_reg.sv */
// Result register holding one parsed item for the output stream.
`default_nettype none
module sfd_out_reg
  import sfd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire logic    res_valid_i,
  input  wire result_t res_i,
  input  wire logic    ready_i,
  output logic         valid_o,
  output result_t      res_o
);

  logic    valid_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

/* rtl/serial_frame_deframer_top.sv */
// Top level of the serial frame deframer: input register, parser, result register.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/tready          tdata rx_byte, tlast end_of_chunk
//  m_axis    out  m_axis_tvalid/tready          tdata data/cmd/index, tuser kind
//  cfg       in   cfg_we_i                      cfg_index_i, cfg_wdata_i
//
// One byte per cycle sustained while m_axis_tready does not stall the output; a request
// passes through the input register, then the parse logic into the result register.
// Reset clears phase, counters and valid flags; config registers take their defaults.
// A stalled output holds its result and the byte in the input register; the input
// register takes a request while it is empty or while its byte moves on.
`default_nettype none
module serial_frame_deframer_top
  import sfd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [ByteW-1:0]    s_axis_tdata,   // [7:0] rx_byte
  input  wire logic                s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // [7:0] data_byte, [15:8] command_code,
                                                   // [22:16] byte_index, [23] zero
  output logic [KindW-1:0]         m_axis_tuser,   // [1:0] kind
  output logic                     m_axis_tlast,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic [ByteW-1:0] sync_q;
  logic [LenW-1:0]  maxpay_q;
  logic             advance;
  logic             take;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign take          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= SyncReset;
      maxpay_q <= MaxPayReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegSyncByte:   sync_q   <= cfg_wdata_i;
        RegMaxPayload: maxpay_q <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  sfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .rx_byte_i     (in_byte_q),
    .last_i        (in_last_q),
    .sync_byte_i   (sync_q),
    .max_payload_i (maxpay_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  sfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_i     (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.byte_index, out_res.command_code, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = (out_res.kind != KIND_DATA);

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_DATA || m_axis_tuser == KIND_GOOD ||
                       m_axis_tuser == KIND_BAD))
    else $error("reserved kind code on output");

  a_no_take_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !take)
    else $error("parser advanced while result register was stalled");

endmodule
`default_nettype wire
